// ===== rtl/scs1_pkg.sv =====
// Shared types, byte codes and the navigation key table for the set 1 decoder.
// No dependencies; scs1_front, scs1_resolve and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package scs1_pkg;

    // Keymap geometry: one unshifted and one shifted half.
    localparam int MAP_ENTRIES = 128;
    localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
    localparam int MAP_DEPTH   = 2 * MAP_ENTRIES;
    localparam int MAP_ADDR_W  = $clog2(MAP_DEPTH);

    // Result kinds.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_SPECIAL = 2'd2;

    // Special key codes.
    localparam logic [3:0] SK_UP     = 4'd0;
    localparam logic [3:0] SK_DOWN   = 4'd1;
    localparam logic [3:0] SK_LEFT   = 4'd2;
    localparam logic [3:0] SK_RIGHT  = 4'd3;
    localparam logic [3:0] SK_PGUP   = 4'd4;
    localparam logic [3:0] SK_PGDN   = 4'd5;
    localparam logic [3:0] SK_HOME   = 4'd6;
    localparam logic [3:0] SK_END    = 4'd7;
    localparam logic [3:0] SK_DELETE = 4'd8;
    localparam logic [3:0] SK_INSERT = 4'd9;
    localparam logic [3:0] SK_CTRL_S = 4'd10;
    localparam logic [3:0] SK_CTRL_C = 4'd11;

    // Item modes.
    localparam logic MODE_DECODE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // Scancode set 1 bytes.
    localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_NAV_UP       = 8'h48;
    localparam logic [7:0] SC_NAV_DOWN     = 8'h50;
    localparam logic [7:0] SC_NAV_LEFT     = 8'h4B;
    localparam logic [7:0] SC_NAV_RIGHT    = 8'h4D;
    localparam logic [7:0] SC_NAV_PGUP     = 8'h49;
    localparam logic [7:0] SC_NAV_PGDN     = 8'h51;
    localparam logic [7:0] SC_NAV_HOME     = 8'h47;
    localparam logic [7:0] SC_NAV_END      = 8'h4F;
    localparam logic [7:0] SC_NAV_DELETE   = 8'h53;
    localparam logic [7:0] SC_NAV_INSERT   = 8'h52;

    // Characters that turn into control specials.
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_LOWER_C = 8'h63;
    localparam logic [7:0] CH_UPPER_C = 8'h43;

    typedef struct packed {
        logic                 mode;
        logic [7:0]           scan_byte;
        logic [MAP_IDX_W-1:0] entry_index;
        logic                 entry_shifted;
        logic [7:0]           entry_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] char_out;
        logic [3:0] special_key;
    } t_out_item;

    // Decode decision carried from the front end to the resolve stage.
    typedef struct packed {
        logic       is_lookup;
        logic       is_special;
        logic [3:0] key;
        logic       ctrl;
    } t_dec;

    typedef struct packed {
        logic       hit;
        logic [3:0] key;
    } t_nav;

    // Navigation key for the byte that follows the extended prefix.
    function automatic t_nav nav_lookup(input logic [7:0] b);
        t_nav r;
        r.hit = 1'b1;
        case (b)
            SC_NAV_UP:     r.key = SK_UP;
            SC_NAV_DOWN:   r.key = SK_DOWN;
            SC_NAV_LEFT:   r.key = SK_LEFT;
            SC_NAV_RIGHT:  r.key = SK_RIGHT;
            SC_NAV_PGUP:   r.key = SK_PGUP;
            SC_NAV_PGDN:   r.key = SK_PGDN;
            SC_NAV_HOME:   r.key = SK_HOME;
            SC_NAV_END:    r.key = SK_END;
            SC_NAV_DELETE: r.key = SK_DELETE;
            SC_NAV_INSERT: r.key = SK_INSERT;
            default: begin
                r.hit = 1'b0;
                r.key = SK_UP;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scs1_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scs1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/scs1_front.sv =====
// Front end: prefix, shift and ctrl flags, byte classification, keymap addressing.
// Depends on scs1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scs1_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire scs1_pkg::t_in_item                  i_item,
    output scs1_pkg::t_dec                           o_dec,
    output logic                                     o_map_we,
    output logic                                     o_map_re,
    output logic      [scs1_pkg::MAP_ADDR_W-1:0]     o_map_addr
);
    import scs1_pkg::*;

    logic r_prefix, r_shift, r_ctrl;
    logic n_prefix, n_shift, n_ctrl;
    t_nav nav;
    logic [7:0] b;

    assign b   = i_item.scan_byte;
    assign nav = nav_lookup(b);

    always_comb begin
        n_prefix = r_prefix;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        o_dec    = '0;
        if (i_accept && i_item.mode == MODE_DECODE) begin
            if (b == SC_EXT_PREFIX) begin
                n_prefix = 1'b1;
            end else if (r_prefix) begin
                n_prefix = 1'b0;
                if (nav.hit) begin
                    o_dec.is_special = 1'b1;
                    o_dec.key        = nav.key;
                end else if (b == SC_CTRL_MAKE) begin
                    n_ctrl = 1'b1;
                end else if (b == SC_CTRL_BREAK) begin
                    n_ctrl = 1'b0;
                end
            end else if (b inside {SC_LSHIFT_MAKE, SC_RSHIFT_MAKE}) begin
                n_shift = 1'b1;
            end else if (b inside {SC_LSHIFT_BREAK, SC_RSHIFT_BREAK}) begin
                n_shift = 1'b0;
            end else if (b == SC_CTRL_MAKE) begin
                n_ctrl = 1'b1;
            end else if (b == SC_CTRL_BREAK) begin
                n_ctrl = 1'b0;
            end else if (!b[7]) begin
                o_dec.is_lookup = 1'b1;
                o_dec.ctrl      = r_ctrl;
            end
        end
    end

    // Load items write the keymap; decode items read the half picked by shift.
    assign o_map_we   = i_accept && (i_item.mode == MODE_LOAD);
    assign o_map_re   = i_accept && (i_item.mode == MODE_DECODE);
    assign o_map_addr = (i_item.mode == MODE_LOAD)
                      ? {i_item.entry_shifted, i_item.entry_index}
                      : {r_shift, b[MAP_IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= 1'b0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
        end else begin
            r_prefix <= n_prefix;
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scs1_resolve.sv =====
// Resolve stage: turns the decode decision and the keymap byte into a result.
// Depends on scs1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scs1_resolve (
    input  wire scs1_pkg::t_dec   i_dec,
    input  wire logic [7:0]       i_map_char,
    output scs1_pkg::t_out_item   o_item
);
    import scs1_pkg::*;

    always_comb begin
        o_item = '0;
        if (i_dec.is_special) begin
            o_item.result_kind = KIND_SPECIAL;
            o_item.special_key = i_dec.key;
        end else if (i_dec.is_lookup) begin
            if (i_dec.ctrl) begin
                // With ctrl held only s and c mean anything.
                if (i_map_char inside {CH_LOWER_S, CH_UPPER_S}) begin
                    o_item.result_kind = KIND_SPECIAL;
                    o_item.special_key = SK_CTRL_S;
                end else if (i_map_char inside {CH_LOWER_C, CH_UPPER_C}) begin
                    o_item.result_kind = KIND_SPECIAL;
                    o_item.special_key = SK_CTRL_C;
                end
            end else if (i_map_char != 8'd0) begin
                o_item.result_kind = KIND_CHAR;
                o_item.char_out    = i_map_char;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scancode_set1_key_decoder.sv =====
// Top level of the scancode set 1 key decoder: pipeline control and keymap RAM.
// Depends on scs1_pkg, scs1_ram, scs1_front and scs1_resolve.
//
//   Channel  Direction  Handshake                    Payload
//   in       input      i_in_valid / o_in_ready      i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_ready    o_out_item (t_out_item)
//
// Every accepted item yields exactly one result item; load items and bytes that
// decode to nothing give a result of kind none. An item is taken in every cycle
// in which input ready is high. The registered read port of the keymap RAM and
// stage 1 load at the accepting edge, and the output register then loads from
// stage 1 when stage 1 advances; the result is presented from the output register.
// Reset is synchronous and active low; it clears the prefix, shift and ctrl flags
// and the pipeline valid bits. The keymap is not cleared and holds undefined
// bytes until loaded. When the output is stalled the pipeline holds and input
// ready drops only once both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module scancode_set1_key_decoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire scs1_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output scs1_pkg::t_out_item      o_out_item
);
    import scs1_pkg::*;

    logic                  in_fire;
    logic                  s1_adv;
    t_dec                  front_dec;
    logic                  map_we;
    logic                  map_re;
    logic [MAP_ADDR_W-1:0] map_addr;
    logic [7:0]            map_char;
    t_out_item             resolved;

    // Stage 1 holds the decode decision while the RAM read completes.
    logic      r_s1_valid;
    t_dec      r_s1_dec;
    logic      r_out_valid;
    t_out_item r_out_item;

    // Stage 1 moves forward whenever the output register is empty or being taken.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    scs1_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_fire),
        .i_item     (i_in_item),
        .o_dec      (front_dec),
        .o_map_we   (map_we),
        .o_map_re   (map_re),
        .o_map_addr (map_addr)
    );

    // The read data register only loads on a decode acceptance, so it holds its
    // byte while stage 1 is stalled.
    scs1_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_keymap (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_addr),
        .i_wdata (i_in_item.entry_char),
        .i_re    (map_re),
        .i_raddr (map_addr),
        .o_rdata (map_char)
    );

    scs1_resolve u_resolve (
        .i_dec      (r_s1_dec),
        .i_map_char (map_char),
        .o_item     (resolved)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= in_fire;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_dec <= front_dec;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_item <= resolved;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted item always lands in stage 1.
    a_fire_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted item did not reach stage 1");

    // A stalled stage 1 item is never dropped.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("stage 1 item lost during stall");

    // A decode decision is never both a lookup and a navigation special.
    a_dec_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_dec.is_lookup && r_s1_dec.is_special))
        else $error("stage 1 decision is both lookup and special");

    // Character results carry a nonzero byte and no special code.
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.result_kind == KIND_CHAR)
            |-> (o_out_item.char_out != 8'd0 && o_out_item.special_key == SK_UP))
        else $error("character result malformed");

    // Only the three defined result kinds ever leave the block.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.result_kind == KIND_NONE
                      || o_out_item.result_kind == KIND_CHAR
                      || o_out_item.result_kind == KIND_SPECIAL))
        else $error("illegal result kind");

endmodule

`default_nettype wire
